### hw/rtl/fenp_pkg.sv
`timescale 1ns / 1ps
// Types, character codes and board constants for the position string parser.
// No dependencies; used by fenp_step and fen_position_parser.
package fenp_pkg;

	localparam int BOARD_SIDE = 8;

	localparam logic [4:0] ROW_MAX = 5'd31;
	localparam logic [3:0] COL_MAX = 4'd15;
	localparam logic [8:0] HM_SAT  = 9'd256;

	// field order in the string
	localparam logic [2:0] FLD_PLACE  = 3'd0;
	localparam logic [2:0] FLD_SIDE   = 3'd1;
	localparam logic [2:0] FLD_CASTLE = 3'd2;
	localparam logic [2:0] FLD_EP     = 3'd3;
	localparam logic [2:0] FLD_HALF   = 3'd4;
	localparam logic [2:0] FLD_REST   = 3'd5;

	// halfmove scan phases
	localparam logic [1:0] HM_LEAD   = 2'd0;
	localparam logic [1:0] HM_DIGITS = 2'd1;
	localparam logic [1:0] HM_DONE   = 2'd2;

	// piece codes
	localparam logic [2:0] PC_KING   = 3'd0;
	localparam logic [2:0] PC_QUEEN  = 3'd1;
	localparam logic [2:0] PC_ROOK   = 3'd2;
	localparam logic [2:0] PC_BISHOP = 3'd3;
	localparam logic [2:0] PC_KNIGHT = 3'd4;
	localparam logic [2:0] PC_PAWN   = 3'd5;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = "/";
	localparam logic [7:0] CH_DASH  = "-";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_0     = "0";
	localparam logic [7:0] CH_9     = "9";
	localparam logic [7:0] CH_3     = "3";
	localparam logic [7:0] CH_6     = "6";
	localparam logic [7:0] CH_LA    = "a";
	localparam logic [7:0] CH_LH    = "h";
	localparam logic [7:0] CH_LZ    = "z";
	localparam logic [7:0] CH_UW    = "W";
	localparam logic [7:0] CH_LW    = "w";
	localparam logic [7:0] CH_UB    = "B";
	localparam logic [7:0] CH_LB    = "b";
	localparam logic [7:0] CH_UK    = "K";
	localparam logic [7:0] CH_UQ    = "Q";
	localparam logic [7:0] CH_LK    = "k";
	localparam logic [7:0] CH_LQ    = "q";
	localparam logic [7:0] CH_UR    = "R";
	localparam logic [7:0] CH_UN    = "N";
	localparam logic [7:0] CH_UP    = "P";
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CASE_GAP = 8'd32;

	// home squares: white king, white h rook, white a rook, then black
	localparam int LAST_ROW = (BOARD_SIDE - 1) * BOARD_SIDE;
	localparam logic [5:0] HOME_SQ [6] = '{
		6'(LAST_ROW + 4), 6'(LAST_ROW + BOARD_SIDE - 1), 6'(LAST_ROW),
		6'd4, 6'(BOARD_SIDE - 1), 6'd0
	};
	localparam logic [2:0] HOME_PC [6] = '{
		PC_KING, PC_ROOK, PC_ROOK, PC_KING, PC_ROOK, PC_ROOK
	};

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_string;
	} fenp_in_t;

	typedef struct packed {
		logic       kind;
		logic [5:0] square;
		logic [2:0] piece;
		logic       is_black;
		logic       status;
		logic       black_to_move;
		logic [3:0] castle_rights;
		logic       ep_valid;
		logic [5:0] ep_square;
		logic [7:0] halfmove;
		logic       last;
	} fenp_out_t;

	typedef struct packed {
		logic [2:0] field_idx;
		logic       in_token;
		logic [4:0] row_pos;
		logic [3:0] col_pos;
		logic       pend_v;
		logic [3:0] pend_d;
		logic       err;
		logic [5:0] home;
		logic       side_black;
		logic       cas_given;
		logic [3:0] cas_bits;
		logic       cas_stop;
		logic       ep_dash;
		logic [2:0] ep_file;
		logic       ep_rank6;
		logic [1:0] ep_count;
		logic [8:0] hm_mag;
		logic       hm_neg;
		logic [1:0] hm_phase;
	} fenp_state_t;

	localparam fenp_state_t ST_RESET = '0;

	typedef struct packed {
		logic      plc_v;
		fenp_out_t plc;
		logic      sum_v;
		fenp_out_t sum;
	} fenp_res_t;

endpackage

### hw/rtl/fenp_step.sv
`timescale 1ns / 1ps
// Per-character next-state and result logic of the position string parser.
// Depends on fenp_pkg.
module fenp_step import fenp_pkg::*; (
	input  fenp_state_t st,
	input  fenp_in_t    chr,
	output fenp_state_t st_nxt,
	output fenp_res_t   res
);

	function automatic fenp_state_t end_token(fenp_state_t s);
		fenp_state_t r;
		r = s;
		if (s.field_idx == FLD_PLACE) begin
			r.pend_v = 1'b0;
			r.pend_d = '0;
		end
		if (s.field_idx == FLD_EP && !s.ep_dash && s.ep_count < 2'd2)
			r.err = 1'b1;
		if (s.field_idx < FLD_REST)
			r.field_idx = s.field_idx + 3'd1;
		r.in_token = 1'b0;
		return r;
	endfunction

	logic [7:0]  c;
	logic        is_dig;
	logic [3:0]  dval;
	logic        first;
	logic [6:0]  two_val;
	logic [3:0]  delta;
	logic [5:0]  rsum;
	logic [5:0]  rdec;
	logic [4:0]  csum;
	logic [3:0]  colf;
	logic        blk;
	logic [7:0]  up;
	logic [7:0]  file_off;
	logic [2:0]  pc;
	logic        pc_ok;
	logic [5:0]  sq;
	logic [12:0] mag10;
	logic [1:0]  ph;
	logic        take;
	fenp_state_t ns;
	fenp_state_t es;
	logic [3:0]  home_cr;
	logic [5:0]  ep_base;

	assign c        = chr.ch;
	assign is_dig   = (c >= CH_0) && (c <= CH_9);
	assign dval     = c[3:0];
	assign first    = !st.in_token;
	assign two_val  = 7'(st.pend_d) * 7'd10 + 7'(dval);
	assign delta    = two_val[6:3];
	assign rsum     = 6'(st.row_pos) + 6'(delta);
	assign rdec     = rsum - 6'd1;
	assign csum     = 5'(st.col_pos) + (st.pend_v ? 5'(st.pend_d) : 5'd0);
	assign colf     = (csum > 5'(COL_MAX)) ? COL_MAX : csum[3:0];
	assign blk      = (c >= CH_LA) && (c <= CH_LZ);
	assign up       = blk ? c - CASE_GAP : c;
	assign file_off = c - CH_LA;
	assign sq       = {st.row_pos[2:0], colf[2:0]};
	assign mag10    = 13'(st.hm_mag) * 13'd10 + 13'(dval);

	always_comb begin
		pc_ok = 1'b1;
		case (up)
			CH_UK:   pc = PC_KING;
			CH_UQ:   pc = PC_QUEEN;
			CH_UR:   pc = PC_ROOK;
			CH_UB:   pc = PC_BISHOP;
			CH_UN:   pc = PC_KNIGHT;
			CH_UP:   pc = PC_PAWN;
			default: begin
				pc    = PC_KING;
				pc_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		ns      = st;
		res     = '0;
		ph      = st.hm_phase;
		take    = 1'b1;
		if (!st.err) begin
			if (c == CH_SPACE) begin
				if (st.in_token)
					ns = end_token(st);
			end else begin
				ns.in_token = 1'b1;
				case (st.field_idx)
					FLD_PLACE: begin
						if (is_dig) begin
							if (st.pend_v) begin
								ns.pend_v = 1'b0;
								ns.pend_d = '0;
								if (rsum == '0)
									ns.err = 1'b1;
								else
									ns.row_pos = (rdec > 6'(ROW_MAX)) ? ROW_MAX : rdec[4:0];
							end else begin
								ns.pend_v = 1'b1;
								ns.pend_d = dval;
							end
						end else begin
							ns.pend_v  = 1'b0;
							ns.pend_d  = '0;
							ns.col_pos = colf;
							if (c == CH_SLASH) begin
								ns.row_pos = (st.row_pos == ROW_MAX) ? ROW_MAX
								                                     : st.row_pos + 5'd1;
								ns.col_pos = '0;
							end else if (st.row_pos >= 5'(BOARD_SIDE) ||
							             colf >= 4'(BOARD_SIDE) || !pc_ok) begin
								ns.err = 1'b1;
							end else begin
								res.plc_v          = 1'b1;
								res.plc.square     = sq;
								res.plc.piece      = pc;
								res.plc.is_black   = blk;
								for (int i = 0; i < 6; i++) begin
									if (sq == HOME_SQ[i])
										ns.home[i] = (pc == HOME_PC[i]) &&
										             ((i >= 3) ? blk : !blk);
								end
								ns.col_pos = (colf == COL_MAX) ? COL_MAX : colf + 4'd1;
							end
						end
					end
					FLD_SIDE: begin
						if (first) begin
							if (c == CH_LW || c == CH_UW)
								ns.side_black = 1'b0;
							else if (c == CH_LB || c == CH_UB)
								ns.side_black = 1'b1;
							else
								ns.err = 1'b1;
						end
					end
					FLD_CASTLE: begin
						if (first) begin
							ns.cas_given = 1'b1;
							ns.cas_bits  = '0;
						end
						if (!st.cas_stop) begin
							if (c == CH_DASH)
								ns.cas_stop = 1'b1;
							else if (c == CH_UK)
								ns.cas_bits[0] = 1'b1;
							else if (c == CH_UQ)
								ns.cas_bits[1] = 1'b1;
							else if (c == CH_LK)
								ns.cas_bits[2] = 1'b1;
							else if (c == CH_LQ)
								ns.cas_bits[3] = 1'b1;
						end
					end
					FLD_EP: begin
						if (first) begin
							if (c == CH_DASH)
								ns.ep_dash = 1'b1;
							else if (c >= CH_LA && c <= CH_LH) begin
								ns.ep_file  = file_off[2:0];
								ns.ep_count = 2'd1;
							end else
								ns.err = 1'b1;
						end else if (!st.ep_dash) begin
							if (st.ep_count == 2'd1 && (c == CH_3 || c == CH_6)) begin
								ns.ep_rank6 = (c == CH_6);
								ns.ep_count = 2'd2;
							end else
								ns.err = 1'b1;
						end
					end
					FLD_HALF: begin
						if (ph == HM_LEAD) begin
							if (c >= CH_TAB && c <= CH_CR)
								take = 1'b0;
							else begin
								ph = HM_DIGITS;
								if (c == CH_PLUS || c == CH_DASH) begin
									ns.hm_neg = (c == CH_DASH);
									take      = 1'b0;
								end
							end
						end
						if (take && ph == HM_DIGITS) begin
							if (is_dig)
								ns.hm_mag = (mag10 > 13'(HM_SAT)) ? HM_SAT : mag10[8:0];
							else
								ph = HM_DONE;
						end
						ns.hm_phase = ph;
					end
					default: begin
					end
				endcase
			end
		end

		// last character: close the open field, report and start over
		es = (!ns.err && ns.in_token) ? end_token(ns) : ns;

		// ep rank 6 is row 2, rank 3 is row 5
		ep_base = {es.ep_rank6 ? 3'd2 : 3'd5, es.ep_file};

		home_cr = {es.home[3] & es.home[5], es.home[3] & es.home[4],
		           es.home[0] & es.home[2], es.home[0] & es.home[1]};

		if (chr.end_of_string) begin
			res.sum_v      = 1'b1;
			res.sum.kind   = 1'b1;
			res.sum.last   = 1'b1;
			if (es.err) begin
				res.sum.status = 1'b1;
			end else begin
				res.sum.black_to_move = es.side_black;
				res.sum.castle_rights = es.cas_given ? es.cas_bits : home_cr;
				res.sum.ep_valid      = !es.ep_dash && es.ep_count == 2'd2;
				if (!es.ep_dash && es.ep_count == 2'd2)
					res.sum.ep_square = es.side_black ? ep_base - 6'd8 : ep_base + 6'd8;
				res.sum.halfmove = es.hm_neg ? 8'd0 :
				                   (es.hm_mag > 9'd255) ? 8'd255 : es.hm_mag[7:0];
			end
			ns = ST_RESET;
		end
		st_nxt = ns;
	end

endmodule

### hw/rtl/fen_position_parser.sv
`timescale 1ns / 1ps
// Top level of the chess position string parser: input register, step logic,
// two-entry result queue. Depends on fenp_pkg and fenp_step.
//
// Usage
//  - chr channel: one character per item (chr_data.ch), end_of_string set on
//    the last character of a string. Fields are split by runs of spaces.
//  - res channel: result items. kind 0 is a placed piece (square, piece,
//    is_black); kind 1 is the summary of a string with last set: status,
//    side to move, castling rights, en passant square and halfmove clock.
//    A character yields at most two items: a piece, then the summary.
//  - Path: a character taken into the input register has its results
//    written into the result queue, whose head drives res_data.
//  - Throughput: one character per cycle while each gives at most one
//    result and res_ready is high. A character that gives two results waits
//    in the input register until the result queue is empty, and the
//    character after it then waits for a free slot.
//  - The result queue, not res_ready, sets chr_ready, so the input side sees
//    no combinational path from the output side.
//  - Stall: with res_ready low the queue (two items) and the input register
//    fill, then chr_ready drops; nothing is lost or repeated.
//  - Reset (arst_n low): parser state back to the start of a string, queue
//    and input register emptied. The parser also returns there by itself
//    after every summary.
module fen_position_parser import fenp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      chr_valid,
	output logic      chr_ready,
	input  fenp_in_t  chr_data,
	output logic      res_valid,
	input  logic      res_ready,
	output fenp_out_t res_data
);

	// input register
	logic        vld_s1;
	fenp_in_t    chr_s1;

	// parser state
	fenp_state_t st_q;
	fenp_state_t st_nxt;
	fenp_res_t   rs;

	// result queue: entry 0 is the head
	fenp_out_t   q0_q;
	fenp_out_t   q1_q;
	logic [1:0]  cnt_q;

	logic [1:0]  n_res;
	logic [1:0]  free_slots;
	logic        proc;
	logic        pop;
	logic [1:0]  rc;
	logic [1:0]  pn;
	fenp_out_t   r0;
	fenp_out_t   p0;
	fenp_out_t   e0;
	fenp_out_t   e1;

	fenp_step u_step (
		.st     (st_q),
		.chr    (chr_s1),
		.st_nxt (st_nxt),
		.res    (rs)
	);

	// an item moves on only if all its results fit in the queue as it stands
	assign n_res      = 2'(rs.plc_v) + 2'(rs.sum_v);
	assign free_slots = 2'd2 - cnt_q;
	assign proc       = vld_s1 && (n_res <= free_slots);
	assign chr_ready  = !vld_s1 || proc;

	assign res_valid  = (cnt_q != 2'd0);
	assign res_data   = q0_q;
	assign pop        = res_valid && res_ready;

	// what remains after the pop, then the new results appended behind it
	assign rc = cnt_q - 2'(pop);
	assign pn = proc ? n_res : 2'd0;
	assign r0 = pop ? q1_q : q0_q;
	assign p0 = rs.plc_v ? rs.plc : rs.sum;
	assign e0 = (rc != 2'd0) ? r0 : p0;
	assign e1 = (rc == 2'd2) ? q1_q : ((rc == 2'd1) ? p0 : rs.sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			st_q   <= ST_RESET;
			cnt_q  <= 2'd0;
		end else begin
			if (chr_ready)
				vld_s1 <= chr_valid;
			if (proc)
				st_q <= st_nxt;
			cnt_q <= rc + pn;
		end
	end

	always_ff @(posedge clk) begin
		if (chr_valid && chr_ready)
			chr_s1 <= chr_data;
		q0_q <= e0;
		q1_q <= e1;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("result queue over its depth");

	a_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !proc |=> vld_s1 && $stable(chr_s1))
		else $error("waiting character lost or changed");

	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind |-> res_data.last)
		else $error("summary without last");

	a_plc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.kind |-> !res_data.last && !res_data.status &&
		res_data.piece <= PC_PAWN)
		else $error("malformed placement item");

	a_reset_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		proc && chr_s1.end_of_string |=> st_q == ST_RESET)
		else $error("parser state not cleared after summary");
`endif

endmodule
